### design/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared sizes, operation codes and the result record of the deadline timer
// table.
// ----------------------------------------------------------------------------
`default_nettype none

package dtt_pkg;

   localparam int SLOTS     = 8;
   localparam int TIME_BITS = 16;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_SCHED  = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   typedef struct packed {
      logic [15:0] current_time;
      logic [15:0] next_due;
      logic        next_valid;
      logic [7:0]  pending_mask;
      logic [7:0]  fired_mask;
   } dtt_result_type;

endpackage

`default_nettype wire

### design/dtt_core.sv
// ----------------------------------------------------------------------------
// dtt_core
// Time base, pending flags and the due-time memory. Applies one command, then
// scans every slot through the memory's read port to fire expired slots and
// find the earliest remaining deadline.
// ----------------------------------------------------------------------------
`default_nettype none

module dtt_core
   import dtt_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [1:0]     start_op,
   input  wire logic [2:0]     start_slot,
   input  wire logic [15:0]    start_delay,
   output logic                idle,
   output logic                res_valid,
   input  wire logic           res_take,
   output dtt_result_type      res
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_TAIL = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam logic [TIME_BITS-1:0] THALF = {1'b1, {(TIME_BITS-1){1'b0}}};
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

   logic [1:0]           state_ff, state_in;
   logic [TIME_BITS-1:0] time_ff;
   logic [SLOTS-1:0]     pend_ff;
   logic [SLOT_BITS-1:0] cnt_ff;
   logic [SLOT_BITS-1:0] eval_idx_ff;
   logic                 rd_valid_ff;
   logic [TIME_BITS-1:0] rd_data_ff;
   logic                 found_ff;
   logic [TIME_BITS-1:0] best_key_ff;
   logic [TIME_BITS-1:0] best_due_ff;
   logic [7:0]           fired_ff;
   logic [7:0]           pmask_ff;

   logic [TIME_BITS-1:0] due_mem [SLOTS];

   logic [SLOT_BITS-1:0] start_idx;
   logic                 slot_ok;
   logic                 mem_we;
   logic                 mem_re;
   logic [TIME_BITS-1:0] due_gap;
   logic                 is_due;
   logic [TIME_BITS-1:0] key;
   logic                 eval_pend;
   logic                 eval_vis;

   assign start_idx = SLOT_BITS'(start_slot);
   assign slot_ok   = (32'(start_slot) < 32'(SLOTS));
   assign mem_we    = start && (start_op == OP_SCHED) && slot_ok;
   assign mem_re    = (state_ff == ST_SCAN);

   assign due_gap   = rd_data_ff - time_ff;
   assign is_due    = (due_gap == '0) || due_gap[TIME_BITS-1];
   assign key       = due_gap ^ THALF;
   assign eval_pend = rd_valid_ff && pend_ff[eval_idx_ff];
   assign eval_vis  = (32'(eval_idx_ff) < 32'd8);

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);

   always_comb begin
      res.fired_mask   = fired_ff;
      res.pending_mask = pmask_ff;
      res.next_valid   = found_ff;
      res.next_due     = found_ff ? 16'(best_due_ff) : 16'd0;
      res.current_time = 16'(time_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_SCAN;
         ST_SCAN: if (cnt_ff == LAST_SLOT) state_in = ST_TAIL;
         ST_TAIL: state_in = ST_DONE;
         ST_DONE: if (res_take) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // due-time memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         due_mem[start_idx] <= time_ff + TIME_BITS'(start_delay);
      end
      if (mem_re) begin
         rd_data_ff <= due_mem[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         time_ff     <= '0;
         pend_ff     <= '0;
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= mem_re;
         if (start) begin
            cnt_ff   <= '0;
            found_ff <= 1'b0;
            fired_ff <= '0;
            pmask_ff <= '0;
            if (start_op == OP_TICK) begin
               time_ff <= time_ff + 1'b1;
            end else if (start_op == OP_SCHED && slot_ok) begin
               pend_ff[start_idx] <= 1'b1;
            end else if (start_op == OP_CANCEL && slot_ok) begin
               pend_ff[start_idx] <= 1'b0;
            end
         end
         if (mem_re) begin
            eval_idx_ff <= cnt_ff;
            cnt_ff      <= cnt_ff + 1'b1;
         end
         if (eval_pend) begin
            if (is_due) begin
               pend_ff[eval_idx_ff] <= 1'b0;
               if (eval_vis) begin
                  fired_ff[3'(eval_idx_ff)] <= 1'b1;
               end
            end else begin
               if (eval_vis) begin
                  pmask_ff[3'(eval_idx_ff)] <= 1'b1;
               end
               // ascending scan with strict compare keeps the lowest slot on ties
               if (!found_ff || key < best_key_ff) begin
                  found_ff    <= 1'b1;
                  best_key_ff <= key;
                  best_due_ff <= rd_data_ff;
               end
            end
         end
      end
   end

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("command started while a scan is running");

   a_time_only_tick: assert property (@(posedge clock) disable iff (reset)
      start && start_op != OP_TICK |=> $stable(time_ff))
      else $error("time base moved on a non-tick item");

   a_masks_disjoint: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (res.fired_mask & res.pending_mask) == 8'd0)
      else $error("slot both fired and pending");

   a_next_matches: assert property (@(posedge clock) disable iff (reset)
      res_valid && SLOTS <= 8 |-> res.next_valid == (res.pending_mask != 8'd0))
      else $error("next_valid disagrees with pending mask");

   a_no_due_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.next_valid |-> res.next_due == 16'd0)
      else $error("next_due set with nothing pending");

endmodule

`default_nettype wire

### design/deadline_timer_table_top.sv
// ----------------------------------------------------------------------------
// deadline_timer_table_top
// One-shot timer table: tick, schedule and cancel commands in, one status
// item out per command.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser
//  req_    | in  | slot[2:0] delay[18:3]                      | operation[1:0]
//  rsp_    | out | fired_mask[7:0] pending_mask[15:8]         | -
//          |     | next_valid[16] next_due[32:17]             |
//          |     | current_time[48:33]                        |
//
//  An item passes through the accept cycle, one memory read per slot, an
//  evaluation of the last read and a hand-off, in that order. The scan runs
//  over the due-time memory's single read port.
//  A new item is taken while the previous result waits in the output register.
//  Reset clears the time base and all pending flags; the memory needs no clear.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_table_top
   import dtt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // slot[2:0], delay[18:3], zero fill
   input  wire logic [1:0]  req_tuser,   // operation[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata    // fired_mask, pending_mask, next_valid,
                                         // next_due, current_time, zero fill
);

   logic           core_idle;
   logic           res_valid;
   logic           res_take;
   logic           start;
   dtt_result_type res;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [55:0]    rsp_data_ff;

   assign req_tready = core_idle;
   assign start      = req_tvalid && core_idle;
   assign res_take   = res_valid && (!rsp_valid_ff || rsp_tready);

   dtt_core u_core (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .start_op    (req_tuser),
      .start_slot  (req_tdata[2:0]),
      .start_delay (req_tdata[18:3]),
      .idle        (core_idle),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res         (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_data_ff <= {7'd0, res.current_time, res.next_due, res.next_valid,
                         res.pending_mask, res.fired_mask};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### sim/deadline_timer_table_top_tb.sv
// ----------------------------------------------------------------------------
// deadline_timer_table_top_tb
// Self-checking bench for the one-shot timer table. Ticks, schedules, cancels
// and the unused operation code go in over the request stream. Every status
// item is checked field by field against a cycle-free model of the slot table
// kept in this file. Both stream sides idle at random, and one phase holds the
// status side off long enough to back the block up into its request port.
// ----------------------------------------------------------------------------
module deadline_timer_table_top_tb
   import dtt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_CYCLES = SLOTS + 3;
   localparam int LONG_HOLD   = 300;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // slot[2:0], delay[18:3], zero fill
   logic [1:0]  req_tuser = '0;   // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // fired_mask, pending_mask, next_valid,
                                  // next_due, current_time, zero fill

   // timer table as the bench sees it
   logic [15:0]      now_ticks;
   logic [15:0]      due_at [SLOTS];
   logic [SLOTS-1:0] armed;

   dtt_result_type status_queue [$];
   int unsigned    mismatch_count = 0;
   bit             gaps_on = 1'b1;
   bit             rsp_hold_req = 1'b0;

   deadline_timer_table_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

   // applies one command to the table and returns the status it must produce
   function automatic dtt_result_type advance_timers(logic [1:0] op, logic [2:0] slot,
                                                     logic [15:0] delay);
      dtt_result_type st;
      logic [15:0]    gap_to_due;
      logic [15:0]    order_key;
      logic [15:0]    best_key;
      bit             found;
      st = '0;
      found = 1'b0;
      best_key = '0;
      case (op)
         OP_TICK: now_ticks = now_ticks + 16'd1;
         OP_SCHED: begin
            if (slot < SLOTS) begin
               due_at[slot] = now_ticks + delay;
               armed[slot] = 1'b1;
            end
         end
         OP_CANCEL: begin
            if (slot < SLOTS) armed[slot] = 1'b0;
         end
         default: ;
      endcase
      for (int i = 0; i < SLOTS; i++) begin
         if (armed[i]) begin
            gap_to_due = due_at[i] - now_ticks;
            // zero or negative distance fires; half range counts as negative
            if (gap_to_due == 16'd0 || gap_to_due[15]) begin
               armed[i] = 1'b0;
               if (i < 8) st.fired_mask[i] = 1'b1;
            end else begin
               order_key = gap_to_due ^ 16'h8000;
               if (i < 8) st.pending_mask[i] = 1'b1;
               if (!found || order_key < best_key) begin
                  found = 1'b1;
                  best_key = order_key;
                  st.next_due = due_at[i];
               end
            end
         end
      end
      st.next_valid = found;
      st.current_time = now_ticks;
      return st;
   endfunction

   function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : status_check
      dtt_result_type got;
      dtt_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[48:0];
         if (status_queue.size() == 0) begin
            $display("%0t: unexpected status item, expected none, got %h", $time, got);
            mismatch_count++;
         end else begin
            want = status_queue.pop_front();
            check_field("fired_mask", 16'(want.fired_mask), 16'(got.fired_mask));
            check_field("pending_mask", 16'(want.pending_mask), 16'(got.pending_mask));
            check_field("next_valid", 16'(want.next_valid), 16'(got.next_valid));
            check_field("next_due", want.next_due, got.next_due);
            check_field("current_time", want.current_time, got.current_time);
         end
      end
   end

   // status side: random stalls, plus one long hold on request
   initial begin : status_ready
      int unsigned held;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_req) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < LONG_HOLD; held++) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_cmd(logic [1:0] op, logic [2:0] slot, logic [15:0] delay);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, delay, slot};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      status_queue.push_back(advance_timers(op, slot, delay));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_cmd();
      int unsigned pick;
      logic [15:0] delay;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         send_cmd(OP_TICK, 3'($urandom), 16'($urandom));
      end else if (pick < 80) begin
         // short delays so slots actually fire under ticks
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: delay = 16'($urandom_range(0, 24));
            6:                delay = 16'($urandom_range(16'h7FFE, 16'h8001));
            7:                delay = 16'($urandom_range(16'hFFF0, 16'hFFFF));
            default:          delay = 16'($urandom);
         endcase
         send_cmd(OP_SCHED, 3'($urandom_range(0, 7)), delay);
      end else if (pick < 95) begin
         send_cmd(OP_CANCEL, 3'($urandom_range(0, 7)), 16'($urandom));
      end else begin
         send_cmd(OP_UNUSED, 3'($urandom), 16'($urandom));
      end
   endtask

   task automatic test_directed();
      logic [15:0] spread [8] = '{16'd7, 16'd3, 16'd9, 16'd3, 16'd12, 16'd5, 16'd20, 16'd1};
      send_cmd(OP_TICK, 3'd0, 16'd0);
      send_cmd(OP_UNUSED, 3'd5, 16'd1234);
      send_cmd(OP_CANCEL, 3'd6, 16'd0);             // idle slot
      send_cmd(OP_SCHED, 3'd0, 16'd0);              // fires at once
      send_cmd(OP_SCHED, 3'd1, 16'h8000);           // half range, fires
      send_cmd(OP_SCHED, 3'd7, 16'hFFFF);           // wraps behind now
      send_cmd(OP_SCHED, 3'd2, 16'h7FFF);           // furthest still ahead
      send_cmd(OP_SCHED, 3'd3, 16'd2);
      send_cmd(OP_SCHED, 3'd4, 16'd2);              // same due as slot 3
      send_cmd(OP_UNUSED, 3'd7, 16'hFFFF);
      send_cmd(OP_TICK, 3'd7, 16'hFFFF);
      send_cmd(OP_TICK, 3'd0, 16'd0);
      send_cmd(OP_CANCEL, 3'd2, 16'd0);             // table empty again
      for (int s = 0; s < 8; s++) send_cmd(OP_SCHED, 3'(s), spread[s]);
      send_cmd(OP_CANCEL, 3'd7, 16'd0);
      send_cmd(OP_SCHED, 3'd1, 16'd6);              // re-arm a pending slot
      send_cmd(OP_TICK, 3'd0, 16'd0);
      send_cmd(OP_TICK, 3'd0, 16'd0);
      wait_idle();
   endtask

   task automatic test_random_traffic(int unsigned count);
      repeat (count) send_random_cmd();
      wait_idle();
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      rsp_hold_req = 1'b1;
      repeat (40) send_random_cmd();
      wait_idle();
      gaps_on = 1'b1;
   endtask

   task automatic test_full_rate(int unsigned count);
      gaps_on = 1'b0;
      repeat (count) send_random_cmd();
      wait_idle();
   endtask

   initial begin
      now_ticks = '0;
      armed = '0;
      for (int s = 0; s < SLOTS; s++) due_at[s] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_traffic(700);
      test_backpressure();
      test_full_rate(300);

      repeat (2 * ITEM_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && status_queue.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### deadline_timer_table_top.f
design/dtt_pkg.sv
design/dtt_core.sv
design/deadline_timer_table_top.sv
sim/deadline_timer_table_top_tb.sv
